### rtl/core/bship_pkg.sv
// shared constants and types for the burning ship escape-time block
package bship_pkg;

	// fixed field widths
	localparam int POINT_W     = 32;
	localparam int COUNT_OUT_W = 16;
	localparam int MAG_W       = 63;
	localparam int MAX_ITER_W  = 16;
	localparam int ESC_LIM_W   = 17;

	// configuration port
	localparam int CFG_DATA_W = 17;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ESC_LIMIT  = 1'b1;

	localparam logic [MAX_ITER_W-1:0] MAX_ITER_RST = 16'd256;
	localparam logic [ESC_LIM_W-1:0]  ESC_LIM_RST  = 17'd65536;

	// parameter defaults
	localparam int FRAC_BITS_DEF   = 28;
	localparam int COUNT_WIDTH_DEF = 16;

	// integer headroom of z above the fraction
	localparam int Z_INT_BITS = 20;

	// products are capped at 2^62
	localparam logic [MAG_W-1:0] PROD_CAP = {1'b1, {(MAG_W-1){1'b0}}};

	// request from the sequencer to the shared multiplier
	typedef struct packed {
		logic start;
		logic half_shift;   // divide by 2^(frac-1) instead of 2^frac
	} mul_req_t;

endpackage

### rtl/core/bship_chan_if.sv
// point request and result request channels
interface bship_point_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [bship_pkg::POINT_W-1:0] point_real;
	logic signed [bship_pkg::POINT_W-1:0] point_imag;

	modport source (output valid, output point_real, output point_imag, input ready);
	modport sink (input valid, input point_real, input point_imag, output ready);
endinterface

interface bship_result_if;
	logic                              valid;
	logic                              ready;
	logic [bship_pkg::COUNT_OUT_W-1:0] iteration_count;
	logic                              escaped;
	logic [bship_pkg::MAG_W-1:0]       final_mag_sq;

	modport source (output valid, output iteration_count, output escaped,
		output final_mag_sq, input ready);
	modport sink (input valid, input iteration_count, input escaped,
		input final_mag_sq, output ready);
endinterface

### rtl/core/burning_ship_escape_iteration.sv
// burning ship escape-time iteration for one point per request
//
// Takes a point c (signed Q4.28 real and imaginary parts), starts from z = 0 and
// repeats z' = (x*x - y*y + cr, 2*|x*y| + ci) while |z|^2 stays below
// escape_limit * 2^FRAC_BITS and the count stays below max_iterations (capped at
// 2^COUNT_WIDTH - 1). The result request carries the iteration count, the escape
// flag and the final |z|^2 in unsigned Q35.28, saturating at 2^63 - 1. z is kept
// in saturating signed Q20.28.
//
// All products go through a single multiplier unit that builds each full
// (FRAC_BITS+20)-bit square or cross product from four half-width partial
// products. One iteration needs three products (cross product, then the two
// squares of the new z, which also give |z|^2) plus one compare step. The block
// takes one point at a time; it accepts the next point while a finished result
// still waits to be taken. Configuration is written through cfg_wr_en /
// cfg_index / cfg_data; the user must write it only while idle, as the block
// itself does not enforce this.
module burning_ship_escape_iteration #(
	parameter int FRAC_BITS   = bship_pkg::FRAC_BITS_DEF,
	parameter int COUNT_WIDTH = bship_pkg::COUNT_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	bship_point_if.sink                        point,
	bship_result_if.source                     result,
	input  logic                               cfg_wr_en,
	input  logic [bship_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bship_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int MW     = FRAC_BITS + bship_pkg::Z_INT_BITS;   // z width
	localparam int MAG_W  = bship_pkg::MAG_W;
	localparam int SW     = MAG_W + 2;                           // signed sum width
	localparam int LIM_W  = (COUNT_WIDTH > bship_pkg::MAX_ITER_W) ?
		COUNT_WIDTH : bship_pkg::MAX_ITER_W;
	localparam int BND_PAD = 64 - bship_pkg::ESC_LIM_W - FRAC_BITS;

	typedef enum logic [2:0] {S_IDLE, S_SQX, S_SQY, S_CHECK, S_XY, S_DONE} state_t;

	// saturate a wide signed sum into the z range
	function automatic logic [MW-1:0] sat_z(input logic signed [SW-1:0] v);
		logic [SW-MW:0] top;
		top = v[SW-1:MW-1];
		if ((top == '0) || (top == '1)) begin
			sat_z = v[MW-1:0];
		end else if (v[SW-1]) begin
			sat_z = {1'b1, {(MW-1){1'b0}}};
		end else begin
			sat_z = {1'b0, {(MW-1){1'b1}}};
		end
	endfunction

	// magnitude of a signed z value, the most negative value included
	function automatic logic [MW-1:0] mag_of(input logic [MW-1:0] v);
		mag_of = v[MW-1] ? (~v + MW'(1)) : v;
	endfunction

	// configuration registers
	logic [bship_pkg::MAX_ITER_W-1:0] max_iter_q;
	logic [bship_pkg::ESC_LIM_W-1:0]  esc_lim_q;

	// sequencer and datapath state
	state_t                              state_q;
	bship_pkg::mul_req_t                 mul_req_q;
	logic signed [bship_pkg::POINT_W-1:0] cr_q, ci_q;
	logic [MW-1:0]                       z_re_q, z_im_q;
	logic [MW-1:0]                       z_re_next_q;
	logic [COUNT_WIDTH-1:0]              cnt_q;
	logic [MAG_W-1:0]                    xx_q, yy_q;
	logic [MAG_W-1:0]                    mag_q;
	logic                                esc_q;

	// result register
	logic                                res_vld_q;
	logic [bship_pkg::COUNT_OUT_W-1:0]   res_cnt_q;
	logic                                res_esc_q;
	logic [MAG_W-1:0]                    res_mag_q;

	// multiplier hookup
	logic [MW-1:0]    mul_a, mul_b;
	logic             mul_done;
	logic [MAG_W-1:0] mul_res;

	// combinational helpers
	logic [MW-1:0]           abs_re, abs_im;
	logic [MAG_W:0]          mag_sum;
	logic [MAG_W-1:0]        mag_sat;
	logic [63:0]             bound;
	logic [LIM_W-1:0]        cnt_ext, cnt_cap, max_ext, limit;
	logic                    keep_going;
	logic signed [SW-1:0]    re_sum, im_sum;
	logic                    pt_take, res_free;

	assign abs_re = mag_of(z_re_q);
	assign abs_im = mag_of(z_im_q);

	// operand select: squares of x and y, then the cross product
	always_comb begin
		case (state_q)
			S_SQX: begin
				mul_a = abs_re;
				mul_b = abs_re;
			end
			S_SQY: begin
				mul_a = abs_im;
				mul_b = abs_im;
			end
			default: begin
				mul_a = abs_re;
				mul_b = abs_im;
			end
		endcase
	end

	bship_mulshift #(
		.FRAC_BITS (FRAC_BITS)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req_q),
		.opa    (mul_a),
		.opb    (mul_b),
		.done   (mul_done),
		.result (mul_res)
	);

	// |z|^2 from the two floored squares, saturating
	assign mag_sum = {1'b0, xx_q} + {1'b0, yy_q};
	assign mag_sat = mag_sum[MAG_W] ? {MAG_W{1'b1}} : mag_sum[MAG_W-1:0];

	// bailout bound in the same fixed-point scale as |z|^2
	assign bound = {{BND_PAD{1'b0}}, esc_lim_q, {FRAC_BITS{1'b0}}};

	// effective iteration limit is capped by the counter range
	assign cnt_ext = LIM_W'(cnt_q);
	assign cnt_cap = LIM_W'({COUNT_WIDTH{1'b1}});
	assign max_ext = LIM_W'(max_iter_q);
	assign limit   = (max_ext < cnt_cap) ? max_ext : cnt_cap;

	assign keep_going = ({1'b0, mag_sat} < bound) && (cnt_ext < limit);

	// new z parts before saturation
	assign re_sum = $signed({2'b00, xx_q}) - $signed({2'b00, yy_q}) + SW'(cr_q);
	assign im_sum = $signed({2'b00, mul_res}) + SW'(ci_q);

	// handshakes
	assign point.ready = (state_q == S_IDLE);
	assign pt_take     = point.valid && point.ready;
	assign res_free    = !res_vld_q || result.ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= bship_pkg::MAX_ITER_RST;
			esc_lim_q  <= bship_pkg::ESC_LIM_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				bship_pkg::REG_MAX_ITER:  max_iter_q <= cfg_data[bship_pkg::MAX_ITER_W-1:0];
				bship_pkg::REG_ESC_LIMIT: esc_lim_q  <= cfg_data[bship_pkg::ESC_LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer, datapath registers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mul_req_q   <= '0;
			cr_q        <= '0;
			ci_q        <= '0;
			z_re_q      <= '0;
			z_im_q      <= '0;
			z_re_next_q <= '0;
			cnt_q       <= '0;
			xx_q        <= '0;
			yy_q        <= '0;
			mag_q       <= '0;
			esc_q       <= 1'b0;
			res_vld_q   <= 1'b0;
			res_cnt_q   <= '0;
			res_esc_q   <= 1'b0;
			res_mag_q   <= '0;
		end else begin
			mul_req_q.start <= 1'b0;
			// downstream took the pending result
			if (res_vld_q && result.ready) begin
				res_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pt_take) begin
						// new point: z and count start from zero, square z first
						cr_q                 <= point.point_real;
						ci_q                 <= point.point_imag;
						z_re_q               <= '0;
						z_im_q               <= '0;
						cnt_q                <= '0;
						mul_req_q.start      <= 1'b1;
						mul_req_q.half_shift <= 1'b0;
						state_q              <= S_SQX;
					end
				end
				S_SQX: begin
					if (mul_done) begin
						xx_q                 <= mul_res;
						mul_req_q.start      <= 1'b1;
						mul_req_q.half_shift <= 1'b0;
						state_q              <= S_SQY;
					end
				end
				S_SQY: begin
					if (mul_done) begin
						yy_q    <= mul_res;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					// bailout test on the squares just formed
					mag_q       <= mag_sat;
					esc_q       <= !({1'b0, mag_sat} < bound);
					z_re_next_q <= sat_z(re_sum);
					if (keep_going) begin
						// doubled cross product: divide by 2^(frac-1)
						mul_req_q.start      <= 1'b1;
						mul_req_q.half_shift <= 1'b1;
						state_q              <= S_XY;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_XY: begin
					if (mul_done) begin
						z_re_q               <= z_re_next_q;
						z_im_q               <= sat_z(im_sum);
						cnt_q                <= cnt_q + COUNT_WIDTH'(1);
						mul_req_q.start      <= 1'b1;
						mul_req_q.half_shift <= 1'b0;
						state_q              <= S_SQX;
					end
				end
				S_DONE: begin
					// hand off once the result register is free
					if (res_free) begin
						res_vld_q <= 1'b1;
						res_cnt_q <= cnt_ext[bship_pkg::COUNT_OUT_W-1:0];
						res_esc_q <= esc_q;
						res_mag_q <= mag_q;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid           = res_vld_q;
	assign result.iteration_count = res_cnt_q;
	assign result.escaped         = res_esc_q;
	assign result.final_mag_sq    = res_mag_q;

endmodule

### rtl/core/bship_mulshift.sv
// shared multiplier: floor(a*b / 2^s) capped at 2^62, four partial products
module bship_mulshift #(
	parameter int FRAC_BITS = bship_pkg::FRAC_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  bship_pkg::mul_req_t                       req,
	input  logic [FRAC_BITS+bship_pkg::Z_INT_BITS-1:0] opa,
	input  logic [FRAC_BITS+bship_pkg::Z_INT_BITS-1:0] opb,
	output logic                                      done,
	output logic [bship_pkg::MAG_W-1:0]               result
);

	localparam int MW = FRAC_BITS + bship_pkg::Z_INT_BITS;
	localparam int HW = (MW + 1) / 2;
	localparam int OW = 2 * HW;
	localparam int PW = 4 * HW;
	localparam int MAG_W = bship_pkg::MAG_W;

	typedef enum logic [1:0] {U_IDLE, U_RUN, U_CAP} ustate_t;

	ustate_t          state_q;
	logic [OW-1:0]    a_q, b_q;
	logic             half_q;
	logic [2:0]       step_q;
	logic [PW-1:0]    acc_q;
	logic [OW-1:0]    pp_s1;
	logic [1:0]       pp_sel_s1;
	logic             pp_vld_s1;
	logic             done_q;
	logic [MAG_W-1:0] res_q;

	logic [HW-1:0]    mul_x, mul_y;
	logic [OW-1:0]    mul_p;
	logic [PW-1:0]    pp_ext;
	logic [PW-1:0]    shifted;
	logic             over;
	logic [MAG_W-1:0] capped;

	// operand halves for the current step
	always_comb begin
		case (step_q[1:0])
			2'd0: begin
				mul_x = a_q[HW-1:0];
				mul_y = b_q[HW-1:0];
			end
			2'd1: begin
				mul_x = a_q[HW-1:0];
				mul_y = b_q[OW-1:HW];
			end
			2'd2: begin
				mul_x = a_q[OW-1:HW];
				mul_y = b_q[HW-1:0];
			end
			default: begin
				mul_x = a_q[OW-1:HW];
				mul_y = b_q[OW-1:HW];
			end
		endcase
	end

	assign mul_p = OW'(mul_x) * OW'(mul_y);

	// place the registered partial product
	always_comb begin
		case (pp_sel_s1)
			2'd0:    pp_ext = PW'(pp_s1);
			2'd1,
			2'd2:    pp_ext = PW'(pp_s1) << HW;
			default: pp_ext = PW'(pp_s1) << OW;
		endcase
	end

	assign shifted = half_q ? (acc_q >> (FRAC_BITS - 1)) : (acc_q >> FRAC_BITS);
	assign over    = (|shifted[PW-1:MAG_W]) || (shifted[MAG_W-1] && (|shifted[MAG_W-2:0]));
	assign capped  = over ? bship_pkg::PROD_CAP : shifted[MAG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= U_IDLE;
			a_q       <= '0;
			b_q       <= '0;
			half_q    <= 1'b0;
			step_q    <= '0;
			acc_q     <= '0;
			pp_s1     <= '0;
			pp_sel_s1 <= '0;
			pp_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
			res_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (pp_vld_s1) begin
				acc_q <= acc_q + pp_ext;
			end
			unique case (state_q)
				U_IDLE: begin
					pp_vld_s1 <= 1'b0;
					if (req.start) begin
						a_q     <= OW'(opa);
						b_q     <= OW'(opb);
						half_q  <= req.half_shift;
						step_q  <= '0;
						acc_q   <= '0;
						state_q <= U_RUN;
					end
				end
				U_RUN: begin
					if (step_q != 3'd4) begin
						pp_s1     <= mul_p;
						pp_sel_s1 <= step_q[1:0];
						pp_vld_s1 <= 1'b1;
						step_q    <= step_q + 3'd1;
					end else begin
						pp_vld_s1 <= 1'b0;
						state_q   <= U_CAP;
					end
				end
				U_CAP: begin
					res_q   <= capped;
					done_q  <= 1'b1;
					state_q <= U_IDLE;
				end
				default: state_q <= U_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule
